// ----- hw/rtl/soa_pkg.sv -----
// ----------------------------------------------------------------------------
// soa_pkg: shared types and constants of the prime set engine
// Word-organised bit store geometry, operation codes, memory request type and
// the mod-12 helpers used by the quadratic form stepper.
// ----------------------------------------------------------------------------
package soa_pkg;

	// field widths
	localparam int unsigned VAL_W  = 16;
	localparam int unsigned CNT_W  = 13;
	localparam int unsigned FUNC_W = 2;

	// largest limit a build honours; a larger register value is saturated
	localparam int unsigned MAX_LIMIT = 65535;

	// bit store: 65536 bits kept as 4096 words of 16 bits
	localparam int unsigned WORD_W   = 16;
	localparam int unsigned BIT_W    = $clog2(WORD_W);
	localparam int unsigned ROW_N    = (1 << VAL_W) / WORD_W;
	localparam int unsigned ROW_W    = $clog2(ROW_N);
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROW_N - 1);

	// first odd candidate of the square clearing pass
	localparam int unsigned SQ_FIRST = 5;

	// residues mod 12 selected by the three forms
	localparam logic [3:0] RES_A_LO = 4'd1;
	localparam logic [3:0] RES_A_HI = 4'd5;
	localparam logic [3:0] RES_B    = 4'd7;
	localparam logic [3:0] RES_C    = 4'd11;
	localparam logic [3:0] MOD_N    = 4'd12;

	typedef enum logic [FUNC_W-1:0] {
		FN_BUILD  = 2'd0,
		FN_TEST   = 2'd1,
		FN_ERASE  = 2'd2,
		FN_SEARCH = 2'd3
	} func_t;

	// the three quadratic forms: 4x2+y2, 3x2+y2, 3x2-y2
	typedef enum logic [1:0] {
		FORM_A = 2'd0,
		FORM_B = 2'd1,
		FORM_C = 2'd2
	} form_t;

	typedef struct packed {
		logic              en;
		logic              we;
		logic [ROW_W-1:0]  addr;
		logic [WORD_W-1:0] wdata;
	} ram_req_t;

	typedef struct packed {
		logic             done;
		logic [CNT_W-1:0] count;
	} bld_stat_t;

	// x mod 12 counter step
	function automatic logic [3:0] m12_inc(logic [3:0] v);
		return (v == MOD_N - 4'd1) ? 4'd0 : v + 4'd1;
	endfunction

	// (v*v) mod 12 for v in 0..11
	function automatic logic [3:0] sq_m12(logic [3:0] v);
		logic [3:0] r;
		case (v)
			4'd0, 4'd6:                r = 4'd0;
			4'd2, 4'd4, 4'd8, 4'd10:   r = 4'd4;
			4'd3, 4'd9:                r = 4'd9;
			default:                   r = 4'd1;
		endcase
		return r;
	endfunction

	// (4*v*v) mod 12
	function automatic logic [3:0] sq4_m12(logic [3:0] v);
		return (v == 4'd0 || v == 4'd3 || v == 4'd6 || v == 4'd9) ? 4'd0 : 4'd4;
	endfunction

	// (3*v*v) mod 12
	function automatic logic [3:0] sq3_m12(logic [3:0] v);
		return v[0] ? 4'd3 : 4'd0;
	endfunction

	function automatic logic [3:0] add12(logic [3:0] a, logic [3:0] b);
		logic [4:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s >= {1'b0, MOD_N}) ? 4'(s - {1'b0, MOD_N}) : s[3:0];
	endfunction

	function automatic logic [3:0] sub12(logic [3:0] a, logic [3:0] b);
		return (a >= b) ? a - b : 4'(a + MOD_N - b);
	endfunction

	// residue test of one form from x mod 12 and y mod 12
	function automatic logic form_hit(form_t f, logic [3:0] xm, logic [3:0] ym);
		logic [3:0] r;
		logic       h;
		unique case (f)
			FORM_A: begin
				r = add12(sq4_m12(xm), sq_m12(ym));
				h = (r == RES_A_LO) || (r == RES_A_HI);
			end
			FORM_B: begin
				r = add12(sq3_m12(xm), sq_m12(ym));
				h = (r == RES_B);
			end
			default: begin
				r = sub12(sq3_m12(xm), sq_m12(ym));
				h = (f == FORM_C) && (r == RES_C);
			end
		endcase
		return h;
	endfunction

	typedef enum logic [3:0] {
		B_IDLE,
		B_CLEAR,
		B_ROOT,
		B_FORM,
		B_FLIP,
		B_SQ_RD,
		B_SQ_CHK,
		B_MUL_RD,
		B_MUL_WR,
		B_MARK_RD,
		B_MARK_WR,
		B_COUNT,
		B_COUNT_LAST,
		B_DONE
	} bld_state_t;

	typedef enum logic [2:0] {
		Q_IDLE,
		Q_BUILD,
		Q_CHK,
		Q_SCAN,
		Q_OUT
	} q_state_t;

endpackage

// ----- hw/rtl/soa_ram.sv -----
// ----------------------------------------------------------------------------
// soa_ram: generic single-port synchronous ram
// One access per cycle, write or read; read data registered, held otherwise.
// ----------------------------------------------------------------------------
module soa_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// storage array and registered read port
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/soa_build.sv -----
// ----------------------------------------------------------------------------
// soa_build: sieve build sequencer
// Clears the store, finds the integer root of the limit, steps the three
// quadratic forms with read-modify-write flips, clears square multiples,
// marks 2 and 3 and counts the set bits, all through one memory port.
// ----------------------------------------------------------------------------
module soa_build (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [soa_pkg::VAL_W-1:0]         lim,
	input  logic [soa_pkg::WORD_W-1:0]        rdata,
	output soa_pkg::ram_req_t                 req,
	output soa_pkg::bld_stat_t                stat
);

	soa_pkg::bld_state_t state_q, state_d;

	logic [soa_pkg::VAL_W-1:0]  lim_q;
	logic [soa_pkg::ROW_W-1:0]  row_q;
	logic [7:0]                 root_q;
	logic [16:0]                rsq_q;
	logic [7:0]                 x_q, y_q;
	logic [3:0]                 xm_q, ym_q;
	soa_pkg::form_t             form_q;
	logic [17:0]                a_q, b_q;
	logic [15:0]                ysq_q;
	logic [15:0]                n_q;
	logic [8:0]                 p_q;
	logic [15:0]                s_q;
	logic [16:0]                k_q;
	logic [soa_pkg::CNT_W-1:0]  cnt_q;
	logic                       rd_vld_q;

	logic [18:0] n_full;
	logic        root_more;
	logic        flip;
	logic        sweep_end;
	logic        adv;
	logic        p_last;
	logic        sq_bit;
	logic        k_in;
	logic [soa_pkg::WORD_W-1:0] mark_bits;
	soa_pkg::bld_state_t after_sweep;

	function automatic logic [soa_pkg::BIT_W:0] popcnt(logic [soa_pkg::WORD_W-1:0] w);
		logic [soa_pkg::BIT_W:0] c;
		c = '0;
		for (int i = 0; i < soa_pkg::WORD_W; i++) begin
			c = c + (soa_pkg::BIT_W + 1)'(w[i]);
		end
		return c;
	endfunction

	// candidate number of the current form
	always_comb begin
		unique case (form_q)
			soa_pkg::FORM_A: n_full = 19'(a_q) + 19'(ysq_q);
			soa_pkg::FORM_B: n_full = 19'(b_q) + 19'(ysq_q);
			default:         n_full = 19'(b_q) - 19'(ysq_q);
		endcase
	end

	assign root_more = (rsq_q <= 17'(lim_q));
	assign flip      = (n_full <= 19'(lim_q))
	                   && soa_pkg::form_hit(form_q, xm_q, ym_q)
	                   && ((form_q != soa_pkg::FORM_C) || (x_q > y_q));
	assign sweep_end = (form_q == soa_pkg::FORM_C) && (y_q == root_q) && (x_q == root_q);
	assign adv       = ((state_q == soa_pkg::B_FORM) && !flip) || (state_q == soa_pkg::B_FLIP);
	assign p_last    = (p_q + 9'd2) > {1'b0, root_q};
	assign sq_bit    = rdata[p_q[soa_pkg::BIT_W-1:0]];
	assign k_in      = (k_q <= 17'(lim_q));
	assign after_sweep = (root_q >= 8'(soa_pkg::SQ_FIRST)) ? soa_pkg::B_SQ_RD
	                                                       : soa_pkg::B_MARK_RD;

	// 2 and 3 join the set only when the limit reaches them
	always_comb begin
		mark_bits    = '0;
		mark_bits[2] = (lim_q >= 16'd2);
		mark_bits[3] = (lim_q >= 16'd3);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= soa_pkg::B_IDLE;
			rd_vld_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_vld_q <= (state_q == soa_pkg::B_COUNT);
		end
	end

	// next state and memory requests
	always_comb begin
		state_d = state_q;
		req     = '0;
		unique case (state_q)
			soa_pkg::B_IDLE: begin
				if (start) state_d = soa_pkg::B_CLEAR;
			end
			soa_pkg::B_CLEAR: begin
				req.en   = 1'b1;
				req.we   = 1'b1;
				req.addr = row_q;
				if (row_q == soa_pkg::ROW_LAST) state_d = soa_pkg::B_ROOT;
			end
			soa_pkg::B_ROOT: begin
				if (!root_more) begin
					state_d = (root_q == 8'd0) ? soa_pkg::B_MARK_RD : soa_pkg::B_FORM;
				end
			end
			soa_pkg::B_FORM: begin
				if (flip) begin
					req.en   = 1'b1;
					req.addr = n_full[soa_pkg::VAL_W-1:soa_pkg::BIT_W];
					state_d  = soa_pkg::B_FLIP;
				end else if (sweep_end) begin
					state_d = after_sweep;
				end
			end
			soa_pkg::B_FLIP: begin
				req.en    = 1'b1;
				req.we    = 1'b1;
				req.addr  = n_q[soa_pkg::VAL_W-1:soa_pkg::BIT_W];
				req.wdata = rdata ^ (soa_pkg::WORD_W'(1) << n_q[soa_pkg::BIT_W-1:0]);
				state_d   = sweep_end ? after_sweep : soa_pkg::B_FORM;
			end
			soa_pkg::B_SQ_RD: begin
				req.en   = 1'b1;
				req.addr = soa_pkg::ROW_W'(p_q[7:soa_pkg::BIT_W]);
				state_d  = soa_pkg::B_SQ_CHK;
			end
			soa_pkg::B_SQ_CHK: begin
				if (sq_bit)      state_d = soa_pkg::B_MUL_RD;
				else if (p_last) state_d = soa_pkg::B_MARK_RD;
				else             state_d = soa_pkg::B_SQ_RD;
			end
			soa_pkg::B_MUL_RD: begin
				if (k_in) begin
					req.en   = 1'b1;
					req.addr = k_q[soa_pkg::VAL_W-1:soa_pkg::BIT_W];
					state_d  = soa_pkg::B_MUL_WR;
				end else begin
					state_d = p_last ? soa_pkg::B_MARK_RD : soa_pkg::B_SQ_RD;
				end
			end
			soa_pkg::B_MUL_WR: begin
				req.en    = 1'b1;
				req.we    = 1'b1;
				req.addr  = k_q[soa_pkg::VAL_W-1:soa_pkg::BIT_W];
				req.wdata = rdata & ~(soa_pkg::WORD_W'(1) << k_q[soa_pkg::BIT_W-1:0]);
				state_d   = soa_pkg::B_MUL_RD;
			end
			soa_pkg::B_MARK_RD: begin
				req.en  = 1'b1;
				state_d = soa_pkg::B_MARK_WR;
			end
			soa_pkg::B_MARK_WR: begin
				req.en    = 1'b1;
				req.we    = 1'b1;
				req.wdata = rdata | mark_bits;
				state_d   = soa_pkg::B_COUNT;
			end
			soa_pkg::B_COUNT: begin
				req.en   = 1'b1;
				req.addr = row_q;
				if (row_q == soa_pkg::ROW_LAST) state_d = soa_pkg::B_COUNT_LAST;
			end
			soa_pkg::B_COUNT_LAST: state_d = soa_pkg::B_DONE;
			soa_pkg::B_DONE:       state_d = soa_pkg::B_IDLE;
			default:               state_d = soa_pkg::B_IDLE;
		endcase
	end

	// loop counters, form stepper and square pass datapath
	always_ff @(posedge clk) begin
		case (state_q)
			soa_pkg::B_IDLE: begin
				lim_q  <= lim;
				row_q  <= '0;
				root_q <= '0;
				rsq_q  <= 17'd1;
			end
			soa_pkg::B_CLEAR: row_q <= row_q + 1'b1;
			soa_pkg::B_ROOT: begin
				if (root_more) begin
					root_q <= root_q + 8'd1;
					rsq_q  <= rsq_q + 17'({root_q, 1'b0}) + 17'd3;
				end else begin
					x_q    <= 8'd1;
					y_q    <= 8'd1;
					xm_q   <= 4'd1;
					ym_q   <= 4'd1;
					form_q <= soa_pkg::FORM_A;
					a_q    <= 18'd4;
					b_q    <= 18'd3;
					ysq_q  <= 16'd1;
					p_q    <= 9'(soa_pkg::SQ_FIRST);
				end
			end
			soa_pkg::B_FORM: begin
				if (flip) n_q <= n_full[soa_pkg::VAL_W-1:0];
			end
			soa_pkg::B_SQ_RD: s_q <= 16'(p_q[7:0]) * 16'(p_q[7:0]);
			soa_pkg::B_SQ_CHK: begin
				if (sq_bit) k_q <= {1'b0, s_q};
				else        p_q <= p_q + 9'd2;
			end
			soa_pkg::B_MUL_RD: begin
				if (!k_in) p_q <= p_q + 9'd2;
			end
			soa_pkg::B_MUL_WR: k_q <= k_q + 17'(s_q);
			soa_pkg::B_MARK_WR: row_q <= '0;
			soa_pkg::B_COUNT:   row_q <= row_q + 1'b1;
			default: ;
		endcase

		// advance over form, then y, then x
		if (adv) begin
			if (form_q != soa_pkg::FORM_C) begin
				form_q <= soa_pkg::form_t'(form_q + 2'd1);
			end else begin
				form_q <= soa_pkg::FORM_A;
				if (y_q != root_q) begin
					y_q   <= y_q + 8'd1;
					ym_q  <= soa_pkg::m12_inc(ym_q);
					ysq_q <= ysq_q + 16'({y_q, 1'b0}) + 16'd1;
				end else begin
					y_q   <= 8'd1;
					ym_q  <= 4'd1;
					ysq_q <= 16'd1;
					x_q   <= x_q + 8'd1;
					xm_q  <= soa_pkg::m12_inc(xm_q);
					a_q   <= a_q + 18'({x_q, 3'b000}) + 18'd4;
					b_q   <= b_q + 18'({x_q, 2'b00}) + 18'({x_q, 1'b0}) + 18'd3;
				end
			end
		end

		// population count over the swept words
		if (state_q == soa_pkg::B_MARK_WR) begin
			cnt_q <= '0;
		end else if (rd_vld_q) begin
			cnt_q <= cnt_q + soa_pkg::CNT_W'(popcnt(rdata));
		end
	end

	assign stat.done  = (state_q == soa_pkg::B_DONE);
	assign stat.count = cnt_q;

	// flips and square clears stay inside the limit
	a_flip_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == soa_pkg::B_FLIP) |-> (n_q <= lim_q))
		else $error("flip beyond limit");

	a_clear_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == soa_pkg::B_MUL_WR) |-> (k_q <= 17'(lim_q)))
		else $error("square clear beyond limit");

endmodule

// ----- hw/rtl/sieve_of_atkin_prime_set.sv -----
// ----------------------------------------------------------------------------
// sieve_of_atkin_prime_set: prime set engine on a sieve bit store
// Builds the prime set up to a limit and answers test, erase and lower bound
// queries; every result carries the current prime count.
// ----------------------------------------------------------------------------
// One item is in work at a time; its result sits in an output register so the
// next item is taken while that result waits. All work goes through the one
// port of a 4096 x 16 bit store. A build clears the store, finds the integer
// root R of the limit, steps the three forms over x and y from 1 to R with a
// read-modify-write per flip, reads each odd root candidate from 5 and clears
// the multiples of the square of each marked one, marks 2 and 3, and counts
// the set bits. A lower bound search reads one 16-bit word at a time, up to
// 4096 words. Before the first build the store reads as empty without a
// clearing pass.
// ----------------------------------------------------------------------------
module sieve_of_atkin_prime_set (
	input  logic        clk,
	input  logic        arst_n,
	// limit register write
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] value
	input  logic [1:0]  s_tuser,   // [1:0] func
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [0] hit, [16:1] prime_value, [29:17] prime_count
);

	soa_pkg::q_state_t state_q, state_d;

	logic [soa_pkg::VAL_W-1:0]  limit_q;
	logic [soa_pkg::VAL_W-1:0]  lim_eff;
	logic                       built_q;
	logic [soa_pkg::CNT_W-1:0]  held_q;
	soa_pkg::func_t             func_q;
	soa_pkg::func_t             func_in;
	logic [soa_pkg::VAL_W-1:0]  value_q;
	logic [soa_pkg::ROW_W-1:0]  srow_q;
	logic                       first_q;
	logic                       res_hit_q;
	logic [soa_pkg::VAL_W-1:0]  res_pv_q;
	logic                       m_tvalid_q;
	logic [31:0]                m_tdata_q;

	soa_pkg::ram_req_t          q_req, b_req, ram_req;
	soa_pkg::bld_stat_t         b_stat;
	logic [soa_pkg::WORD_W-1:0] ram_rdata;
	logic                       bld_start;
	logic                       accept;
	logic                       out_free;
	logic                       chk_bit;
	logic [soa_pkg::WORD_W-1:0] scan_w;

	function automatic logic [soa_pkg::BIT_W-1:0] low_bit(logic [soa_pkg::WORD_W-1:0] w);
		logic [soa_pkg::BIT_W-1:0] idx;
		idx = '0;
		for (int i = soa_pkg::WORD_W - 1; i >= 0; i--) begin
			if (w[i]) idx = soa_pkg::BIT_W'(i);
		end
		return idx;
	endfunction

	assign func_in  = soa_pkg::func_t'(s_tuser);
	assign s_tready = (state_q == soa_pkg::Q_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign chk_bit  = ram_rdata[value_q[soa_pkg::BIT_W-1:0]];
	assign scan_w   = ram_rdata & (first_q
	                  ? ({soa_pkg::WORD_W{1'b1}} << value_q[soa_pkg::BIT_W-1:0])
	                  : {soa_pkg::WORD_W{1'b1}});
	assign lim_eff  = (32'(limit_q) > soa_pkg::MAX_LIMIT)
	                  ? soa_pkg::VAL_W'(soa_pkg::MAX_LIMIT) : limit_q;

	// store port goes to the build sequencer while it runs
	assign ram_req = (state_q == soa_pkg::Q_BUILD) ? b_req : q_req;

	soa_ram #(
		.WIDTH (soa_pkg::WORD_W),
		.DEPTH (soa_pkg::ROW_N)
	) u_store (
		.clk   (clk),
		.en    (ram_req.en),
		.we    (ram_req.we),
		.addr  (ram_req.addr),
		.wdata (ram_req.wdata),
		.rdata (ram_rdata)
	);

	soa_build u_build (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bld_start),
		.lim    (lim_eff),
		.rdata  (ram_rdata),
		.req    (b_req),
		.stat   (b_stat)
	);

	// query state register and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= soa_pkg::Q_IDLE;
			limit_q    <= '0;
			built_q    <= 1'b0;
			held_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) limit_q <= cfg_data;
			if (state_q == soa_pkg::Q_BUILD && b_stat.done) begin
				built_q <= 1'b1;
				held_q  <= b_stat.count;
			end
			if (state_q == soa_pkg::Q_CHK && func_q == soa_pkg::FN_ERASE && chk_bit) begin
				held_q <= held_q - 1'b1;
			end
			if (state_q == soa_pkg::Q_OUT && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready)                        m_tvalid_q <= 1'b0;
		end
	end

	// next state and query store accesses
	always_comb begin
		state_d   = state_q;
		q_req     = '0;
		bld_start = 1'b0;
		unique case (state_q)
			soa_pkg::Q_IDLE: begin
				if (accept) begin
					unique case (func_in) inside
						soa_pkg::FN_BUILD: begin
							bld_start = 1'b1;
							state_d   = soa_pkg::Q_BUILD;
						end
						soa_pkg::FN_TEST, soa_pkg::FN_ERASE: begin
							q_req.en   = built_q;
							q_req.addr = s_tdata[soa_pkg::VAL_W-1:soa_pkg::BIT_W];
							state_d    = built_q ? soa_pkg::Q_CHK : soa_pkg::Q_OUT;
						end
						soa_pkg::FN_SEARCH: begin
							q_req.en   = built_q;
							q_req.addr = s_tdata[soa_pkg::VAL_W-1:soa_pkg::BIT_W];
							state_d    = built_q ? soa_pkg::Q_SCAN : soa_pkg::Q_OUT;
						end
					endcase
				end
			end
			soa_pkg::Q_BUILD: begin
				if (b_stat.done) state_d = soa_pkg::Q_OUT;
			end
			soa_pkg::Q_CHK: begin
				if (func_q == soa_pkg::FN_ERASE && chk_bit) begin
					q_req.en    = 1'b1;
					q_req.we    = 1'b1;
					q_req.addr  = value_q[soa_pkg::VAL_W-1:soa_pkg::BIT_W];
					q_req.wdata = ram_rdata
					              & ~(soa_pkg::WORD_W'(1) << value_q[soa_pkg::BIT_W-1:0]);
				end
				state_d = soa_pkg::Q_OUT;
			end
			soa_pkg::Q_SCAN: begin
				if (scan_w != '0 || srow_q == soa_pkg::ROW_LAST) begin
					state_d = soa_pkg::Q_OUT;
				end else begin
					q_req.en   = 1'b1;
					q_req.addr = srow_q + 1'b1;
				end
			end
			soa_pkg::Q_OUT: begin
				if (out_free) state_d = soa_pkg::Q_IDLE;
			end
			default: state_d = soa_pkg::Q_IDLE;
		endcase
	end

	// item fields, result and output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q    <= func_in;
			value_q   <= s_tdata;
			srow_q    <= s_tdata[soa_pkg::VAL_W-1:soa_pkg::BIT_W];
			first_q   <= 1'b1;
			res_hit_q <= 1'b0;
			res_pv_q  <= '0;
		end
		if (state_q == soa_pkg::Q_CHK) res_hit_q <= chk_bit;
		if (state_q == soa_pkg::Q_SCAN) begin
			first_q <= 1'b0;
			if (scan_w != '0) begin
				res_hit_q <= 1'b1;
				res_pv_q  <= {srow_q, low_bit(scan_w)};
			end else begin
				srow_q <= srow_q + 1'b1;
			end
		end
		if (state_q == soa_pkg::Q_OUT && out_free) begin
			m_tdata_q <= {2'b00, held_q, res_pv_q, res_hit_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// a found prime never lies below the search start
	a_search_ge: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == soa_pkg::Q_OUT && func_q == soa_pkg::FN_SEARCH && res_hit_q)
		|-> (res_pv_q >= value_q))
		else $error("search result below start value");

	// only a search reports a prime value
	a_pv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == soa_pkg::Q_OUT && func_q != soa_pkg::FN_SEARCH) |-> (res_pv_q == '0))
		else $error("prime value set outside search");

	// query side stays off the store while a build owns it
	a_port_owner: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == soa_pkg::Q_BUILD) |-> !q_req.en)
		else $error("query access during build");

endmodule
